### rtl/rpcf_pkg.sv
// ----------------------------------------------------------------------------
// RGB pixel colour filter package
// Filter mode codes, sepia coefficients and the pipeline enable bundle.
// ----------------------------------------------------------------------------
package rpcf_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned MODE_W = 2;
	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [MODE_W-1:0] MODE_INVERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BLEND  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEPIA  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_PASS   = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BLEND_RED   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BLEND_GREEN = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BLEND_BLUE  = 2'd3;

	localparam int unsigned SEPIA_SCALE = 1000;

	// Sepia matrix in thousandths, row by row (red, green, blue output).
	localparam logic [9:0] SEPIA_MILLI [9] = '{
		10'd393, 10'd769, 10'd189,
		10'd349, 10'd686, 10'd168,
		10'd272, 10'd534, 10'd131
	};

	typedef struct packed {
		logic s2;
		logic s3;
	} rpcf_stage_en_t;

	typedef logic [CHAN_W-1:0] chan_t;

	// Coefficient in Q0.frac_bits, rounded to nearest with ties up.
	function automatic logic [31:0] sepia_coef(input int unsigned frac_bits,
			input int unsigned idx);
		logic [63:0] scaled;
		scaled = (64'(SEPIA_MILLI[idx]) << frac_bits) + 64'(SEPIA_SCALE / 2);
		return 32'(scaled / SEPIA_SCALE);
	endfunction

endpackage

### rtl/rpcf_sepia.sv
// ----------------------------------------------------------------------------
// Sepia channel
// One row of the sepia matrix: three registered products, then a registered
// sum, truncation and clamp to 255.
// ----------------------------------------------------------------------------
module rpcf_sepia import rpcf_pkg::*; #(
	parameter int unsigned COEF_FRAC_BITS = 10,
	parameter int unsigned ROW = 0
) (
	input  logic           clk,
	input  rpcf_stage_en_t en,
	input  chan_t          red,
	input  chan_t          green,
	input  chan_t          blue,
	output chan_t          chan_s3
);

	localparam int unsigned PW = COEF_FRAC_BITS + CHAN_W;
	localparam int unsigned SW = PW + 2;
	localparam int unsigned IW = SW - COEF_FRAC_BITS;

	localparam logic [COEF_FRAC_BITS-1:0] COEF_R =
		COEF_FRAC_BITS'(sepia_coef(COEF_FRAC_BITS, ROW * 3));
	localparam logic [COEF_FRAC_BITS-1:0] COEF_G =
		COEF_FRAC_BITS'(sepia_coef(COEF_FRAC_BITS, ROW * 3 + 1));
	localparam logic [COEF_FRAC_BITS-1:0] COEF_B =
		COEF_FRAC_BITS'(sepia_coef(COEF_FRAC_BITS, ROW * 3 + 2));

	logic [PW-1:0] prod_r_s2;
	logic [PW-1:0] prod_g_s2;
	logic [PW-1:0] prod_b_s2;
	logic [SW-1:0] sum;
	logic [IW-1:0] whole;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_r_s2 <= PW'(red) * PW'(COEF_R);
			prod_g_s2 <= PW'(green) * PW'(COEF_G);
			prod_b_s2 <= PW'(blue) * PW'(COEF_B);
		end
	end

	always_comb begin
		sum   = SW'(prod_r_s2) + SW'(prod_g_s2) + SW'(prod_b_s2);
		whole = sum[SW-1:COEF_FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (whole > IW'(8'hff)) begin
				chan_s3 <= 8'hff;
			end else begin
				chan_s3 <= whole[CHAN_W-1:0];
			end
		end
	end

endmodule

### rtl/rgb_pixel_color_filter.sv
// ----------------------------------------------------------------------------
// RGB pixel colour filter
// Invert, blend with a configured colour, sepia or pass-through.
//
// Channel | Direction | Handshake           | Payload
// s_*     | in        | s_tvalid / s_tready | s_tdata: red, green, blue
// m_*     | out       | m_tvalid / m_tready | m_tdata: red, green, blue
// cfg_*   | in        | cfg_we              | cfg_index, cfg_data
//
// Three register stages: input capture, sepia products, then the sepia sum
// and clamp into the output register, where the captured mode picks either
// the sepia or the simple result. One pixel is accepted every cycle while
// the output is taken.
// Each stage moves on when the stage after it is empty or moving, so a stall
// on m_tready holds every pixel in place. Reset clears the valid bits and the
// configuration registers (mode invert, blend colour black).
// ----------------------------------------------------------------------------
module rgb_pixel_color_filter import rpcf_pkg::*; #(
	parameter int unsigned COEF_FRAC_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CHAN_W-1:0]      cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [3*CHAN_W-1:0]    s_tdata,  // red_in, green_in, blue_in
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [3*CHAN_W-1:0]    m_tdata   // red_out, green_out, blue_out
);

	logic [MODE_W-1:0] mode_q;
	chan_t             blend_r_q;
	chan_t             blend_g_q;
	chan_t             blend_b_q;

	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              ready_s1;
	logic              ready_s2;
	logic              ready_s3;
	rpcf_stage_en_t    en;

	chan_t             red_s1;
	chan_t             green_s1;
	chan_t             blue_s1;
	logic [MODE_W-1:0] mode_s1;
	chan_t             simple_r_s1;
	chan_t             simple_g_s1;
	chan_t             simple_b_s1;
	logic [MODE_W-1:0] mode_s2;
	chan_t             simple_r_s2;
	chan_t             simple_g_s2;
	chan_t             simple_b_s2;
	logic              sepia_s3;
	chan_t             simple_r_s3;
	chan_t             simple_g_s3;
	chan_t             simple_b_s3;
	chan_t             sepia_r_s3;
	chan_t             sepia_g_s3;
	chan_t             sepia_b_s3;

	chan_t             in_r;
	chan_t             in_g;
	chan_t             in_b;
	chan_t             simple_r;
	chan_t             simple_g;
	chan_t             simple_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_INVERT;
			blend_r_q <= '0;
			blend_g_q <= '0;
			blend_b_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FILTER_MODE: mode_q    <= cfg_data[MODE_W-1:0];
				REG_BLEND_RED:   blend_r_q <= cfg_data;
				REG_BLEND_GREEN: blend_g_q <= cfg_data;
				REG_BLEND_BLUE:  blend_b_q <= cfg_data;
				default:         mode_q    <= mode_q;
			endcase
		end
	end

	assign ready_s3 = !valid_s3 || m_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;
	assign en.s2    = valid_s1 && ready_s2;
	assign en.s3    = valid_s2 && ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	assign in_r = s_tdata[CHAN_W-1:0];
	assign in_g = s_tdata[2*CHAN_W-1:CHAN_W];
	assign in_b = s_tdata[3*CHAN_W-1:2*CHAN_W];

	// Invert, blend and pass-through are cheap and are settled on entry.
	always_comb begin
		unique case (mode_q)
			MODE_INVERT: begin
				simple_r = ~in_r;
				simple_g = ~in_g;
				simple_b = ~in_b;
			end
			MODE_BLEND: begin
				simple_r = CHAN_W'(({1'b0, in_r} + {1'b0, blend_r_q}) >> 1);
				simple_g = CHAN_W'(({1'b0, in_g} + {1'b0, blend_g_q}) >> 1);
				simple_b = CHAN_W'(({1'b0, in_b} + {1'b0, blend_b_q}) >> 1);
			end
			default: begin
				simple_r = in_r;
				simple_g = in_g;
				simple_b = in_b;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && ready_s1) begin
			red_s1      <= in_r;
			green_s1    <= in_g;
			blue_s1     <= in_b;
			mode_s1     <= mode_q;
			simple_r_s1 <= simple_r;
			simple_g_s1 <= simple_g;
			simple_b_s1 <= simple_b;
		end
		if (en.s2) begin
			mode_s2     <= mode_s1;
			simple_r_s2 <= simple_r_s1;
			simple_g_s2 <= simple_g_s1;
			simple_b_s2 <= simple_b_s1;
		end
		if (en.s3) begin
			sepia_s3    <= (mode_s2 == MODE_SEPIA);
			simple_r_s3 <= simple_r_s2;
			simple_g_s3 <= simple_g_s2;
			simple_b_s3 <= simple_b_s2;
		end
	end

	rpcf_sepia #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS),
		.ROW(0)
	) u_sepia_r (
		.clk    (clk),
		.en     (en),
		.red    (red_s1),
		.green  (green_s1),
		.blue   (blue_s1),
		.chan_s3(sepia_r_s3)
	);

	rpcf_sepia #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS),
		.ROW(1)
	) u_sepia_g (
		.clk    (clk),
		.en     (en),
		.red    (red_s1),
		.green  (green_s1),
		.blue   (blue_s1),
		.chan_s3(sepia_g_s3)
	);

	rpcf_sepia #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS),
		.ROW(2)
	) u_sepia_b (
		.clk    (clk),
		.en     (en),
		.red    (red_s1),
		.green  (green_s1),
		.blue   (blue_s1),
		.chan_s3(sepia_b_s3)
	);

	assign m_tvalid = valid_s3;
	assign m_tdata  = sepia_s3 ? {sepia_b_s3, sepia_g_s3, sepia_r_s3}
	                           : {simple_b_s3, simple_g_s3, simple_r_s3};

endmodule

### sim/rgb_pixel_color_filter_tb.sv
// ----------------------------------------------------------------------------
// RGB pixel colour filter testbench
// Sends pixels through the filter in invert, blend, sepia and pass-through
// modes. Pixels go in with random bursts and gaps, and the output side stalls
// on changing patterns. Each output pixel is checked against a local model of
// the filter. The filter registers are reprogrammed between phases, only
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module rgb_pixel_color_filter_tb import rpcf_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FRAC_BITS    = 10;
	localparam int unsigned RANDOM_ITEMS = 1550;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned MAX_REPORTS  = 10;

	// Sepia matrix in Q0.10, row by row for the red, green and blue outputs.
	localparam int unsigned SEPIA_Q10 [9] = '{
		402, 787, 194,
		357, 702, 172,
		279, 547, 134
	};

	// Red sits in the lowest byte of tdata.
	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
	} pixel_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CHAN_W-1:0]      cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [3*CHAN_W-1:0]    s_tdata   = '0;  // red_in, green_in, blue_in
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [3*CHAN_W-1:0]    m_tdata;         // red_out, green_out, blue_out

	// Local copy of the filter registers, reset values included.
	logic [MODE_W-1:0] filter_mode = MODE_INVERT;
	chan_t             blend_red   = '0;
	chan_t             blend_green = '0;
	chan_t             blend_blue  = '0;

	pixel_t      filtered_pixels [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned burst_left     = 0;
	int unsigned stall_phase    = 0;
	int unsigned stall_pattern  = 0;

	rgb_pixel_color_filter #(
		.COEF_FRAC_BITS(FRAC_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic chan_t sepia_dot(input int unsigned row, input pixel_t px);
		int unsigned acc;
		acc = px.red * SEPIA_Q10[3*row] + px.green * SEPIA_Q10[3*row+1]
			+ px.blue * SEPIA_Q10[3*row+2];
		acc = acc >> FRAC_BITS;
		return (acc > 255) ? 8'd255 : acc[CHAN_W-1:0];
	endfunction

	function automatic chan_t blend_mean(input chan_t a, input chan_t b);
		logic [CHAN_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[CHAN_W:1];
	endfunction

	function automatic pixel_t filter_pixel(input pixel_t px);
		pixel_t res;
		case (filter_mode)
			MODE_INVERT: begin
				res.red   = 8'd255 - px.red;
				res.green = 8'd255 - px.green;
				res.blue  = 8'd255 - px.blue;
			end
			MODE_BLEND: begin
				res.red   = blend_mean(px.red, blend_red);
				res.green = blend_mean(px.green, blend_green);
				res.blue  = blend_mean(px.blue, blend_blue);
			end
			MODE_SEPIA: begin
				res.red   = sepia_dot(0, px);
				res.green = sepia_dot(1, px);
				res.blue  = sepia_dot(2, px);
			end
			default: res = px;
		endcase
		return res;
	endfunction

	// Channel values lean towards the extremes now and then.
	function automatic chan_t random_level();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return chan_t'($urandom);
		endcase
	endfunction

	function automatic pixel_t make_pixel(input chan_t r, input chan_t g, input chan_t b);
		pixel_t px;
		px.red   = r;
		px.green = g;
		px.blue  = b;
		return px;
	endfunction

	// Writes all four registers back to back; only called with the pipeline empty.
	task automatic program_filter(input logic [7:0] mode_data, input chan_t r,
			input chan_t g, input chan_t b);
		logic [CFG_INDEX_W-1:0] regs [4];
		logic [7:0]             values [4];
		regs   = '{REG_FILTER_MODE, REG_BLEND_RED, REG_BLEND_GREEN, REG_BLEND_BLUE};
		values = '{mode_data, r, g, b};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= values[i];
			@(posedge clk);
		end
		cfg_we      <= 1'b0;
		filter_mode = mode_data[MODE_W-1:0];
		blend_red   = r;
		blend_green = g;
		blend_blue  = b;
	endtask

	// Offers one pixel and returns at the edge where the transaction completes.
	// tvalid stays high between pixels of one burst.
	task automatic send_pixel(input pixel_t px);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		filtered_pixels.push_back(filter_pixel(px));
		burst_left--;
	endtask

	task automatic drain_pipeline();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		while (filtered_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input pixel_t want, input pixel_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
				$realtime, what, want.red, want.green, want.blue,
				got.red, got.green, got.blue);
	endtask

	// Reset leaves the filter in invert mode.
	task automatic test_reset_state();
		send_pixel(make_pixel(8'd0, 8'd0, 8'd0));
		send_pixel(make_pixel(8'd255, 8'd255, 8'd255));
		send_pixel(make_pixel(8'h55, 8'hAA, 8'h0F));
	endtask

	task automatic test_invert();
		drain_pipeline();
		program_filter(8'(MODE_INVERT), 8'd255, 8'd255, 8'd255);
		send_pixel(make_pixel(8'hAA, 8'h55, 8'hF0));
		send_pixel(make_pixel(8'd1, 8'd254, 8'd128));
	endtask

	task automatic test_blend();
		drain_pipeline();
		program_filter(8'(MODE_BLEND), 8'd255, 8'd255, 8'd255);
		send_pixel(make_pixel(8'd0, 8'd0, 8'd0));
		send_pixel(make_pixel(8'd255, 8'd255, 8'd255));
		send_pixel(make_pixel(8'd1, 8'd2, 8'd3));
		drain_pipeline();
		program_filter(8'(MODE_BLEND), 8'd0, 8'd0, 8'd0);
		send_pixel(make_pixel(8'd255, 8'd255, 8'd255));
		send_pixel(make_pixel(8'd1, 8'd0, 8'd255));
		drain_pipeline();
		program_filter(8'(MODE_BLEND), 8'h80, 8'h7F, 8'h01);
		send_pixel(make_pixel(8'h81, 8'h7F, 8'hFE));
		send_pixel(make_pixel(8'h00, 8'hFF, 8'h01));
	endtask

	// White saturates the red and green rows; single primaries check each column.
	task automatic test_sepia();
		drain_pipeline();
		program_filter(8'(MODE_SEPIA), 8'h12, 8'h34, 8'h56);
		send_pixel(make_pixel(8'd255, 8'd255, 8'd255));
		send_pixel(make_pixel(8'd0, 8'd0, 8'd0));
		send_pixel(make_pixel(8'd255, 8'd0, 8'd0));
		send_pixel(make_pixel(8'd0, 8'd255, 8'd0));
		send_pixel(make_pixel(8'd0, 8'd0, 8'd255));
		send_pixel(make_pixel(8'd100, 8'd100, 8'd100));
		send_pixel(make_pixel(8'd200, 8'd180, 8'd90));
	endtask

	task automatic test_pass_through();
		drain_pipeline();
		program_filter(8'(MODE_PASS), 8'd7, 8'd8, 8'd9);
		send_pixel(make_pixel(8'h5A, 8'hA5, 8'hFF));
		send_pixel(make_pixel(8'h00, 8'h80, 8'h01));
	endtask

	// Only the low bits of a mode write count.
	task automatic test_wide_mode_value();
		drain_pipeline();
		program_filter({6'b111111, MODE_SEPIA}, 8'd0, 8'd255, 8'd0);
		send_pixel(make_pixel(8'd40, 8'd90, 8'd200));
		drain_pipeline();
		program_filter({6'b101010, MODE_BLEND}, 8'd0, 8'd255, 8'd0);
		send_pixel(make_pixel(8'd40, 8'd90, 8'd200));
		send_pixel(make_pixel(8'd255, 8'd0, 8'd255));
	endtask

	// Phases of random pixels, each with its own register setting. Every phase
	// boundary holds the sender until the pipeline has emptied.
	task automatic test_random_stream();
		int unsigned sent;
		int unsigned count;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain_pipeline();
			program_filter(8'($urandom), random_level(), random_level(), random_level());
			count = $urandom_range(40, 160);
			repeat (count)
				send_pixel(make_pixel(chan_t'($urandom), random_level(), random_level()));
			sent += count;
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** rgb_pixel_color_filter: FAILED **");
			$finish;
		end
	end

	// Output checker and receiver stall patterns.
	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (filtered_pixels.size() == 0) begin
				report_mismatch("unexpected transaction", got, got);
			end else begin
				want = filtered_pixels.pop_front();
				if (got.red !== want.red || got.green !== want.green
						|| got.blue !== want.blue)
					report_mismatch("pixel mismatch", want, got);
			end
		end
		stall_phase++;
		if (stall_phase % 97 == 0)
			stall_pattern = $urandom_range(0, 3);
		case (stall_pattern)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (stall_phase % 4 == 0);
			default: m_tready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_invert();
		test_blend();
		test_sepia();
		test_pass_through();
		test_wide_mode_value();
		test_random_stream();
		drain_pipeline();
		if (mismatch_count == 0 && filtered_pixels.size() == 0) begin
			$display("** rgb_pixel_color_filter: PASSED **");
		end else begin
			$display("** rgb_pixel_color_filter: FAILED **");
		end
		$finish;
	end

endmodule
